FILE: sv/multi_timer_bank_macros.svh
// Assertion macros shared by the timer bank checker.
`ifndef MULTI_TIMER_BANK_MACROS_SVH
`define MULTI_TIMER_BANK_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MTB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mtb_pkg.sv
// Types and constants shared by the timer bank modules.
`default_nettype none
package mtb_pkg;

  localparam int FUNC_W     = 3;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    FN_ALLOC   = 3'd0,
    FN_FREE    = 3'd1,
    FN_BIND    = 3'd2,
    FN_SETTIME = 3'd3,
    FN_TICK    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_ALLOC = 2'd1,
    ST_RUN   = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_TICK,
    S_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic take_in;
    logic alloc_step;
    logic tick_step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_end;
    logic alloc_hit;
    logic tick_stall;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: sv/mtb_ctrl.sv
// Controller state machine that sequences the slot scans of the timer bank.
`default_nettype none
module mtb_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic [mtb_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  output mtb_pkg::dp_cmd_t            cmd,
  input  wire mtb_pkg::dp_sts_t       sts
);

  mtb_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      mtb_pkg::S_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.take_in = 1'b1;
          if (in_func == mtb_pkg::FN_ALLOC) begin
            state_nxt = mtb_pkg::S_ALLOC;
          end else if (in_func == mtb_pkg::FN_TICK) begin
            state_nxt = mtb_pkg::S_TICK;
          end
        end
      end
      mtb_pkg::S_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (sts.alloc_hit || sts.scan_end) begin
          state_nxt = mtb_pkg::S_IDLE;
        end
      end
      mtb_pkg::S_TICK: begin
        cmd.tick_step = 1'b1;
        if (sts.scan_end && !sts.tick_stall) begin
          state_nxt = mtb_pkg::S_FLUSH;
        end
      end
      mtb_pkg::S_FLUSH: begin
        cmd.flush = sts.out_free;
        if (sts.out_free) begin
          state_nxt = mtb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mtb_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/mtb_datapath.sv
// Slot tables, tick counter, scan index, pending expiry and output register.
`default_nettype none
module mtb_datapath #(
  parameter int NUM_SLOTS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mtb_pkg::dp_cmd_t           cmd,
  output mtb_pkg::dp_sts_t                sts,
  input  wire logic [mtb_pkg::FUNC_W-1:0] in_func,
  input  wire logic [4:0]                 in_slot_id,
  input  wire logic [1:0]                 in_queue_id,
  input  wire logic [7:0]                 in_event_byte,
  input  wire logic [31:0]                in_timeout_ticks,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_ok,
  output logic [4:0]                      out_granted_slot,
  output logic                            out_fired,
  output logic [1:0]                      out_fire_queue,
  output logic [7:0]                      out_fire_byte,
  output logic [31:0]                     out_tick_total,
  output logic                            out_last
);

  // Slot ids are five bits wide, so at most 32 slots can be addressed.
  localparam int LIVE = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
  localparam int IW   = (LIVE > 1) ? $clog2(LIVE) : 1;

  mtb_pkg::slot_st_t status_r [LIVE];
  logic [31:0]       remain_r [LIVE];
  logic [1:0]        queue_r  [LIVE];
  logic [7:0]        byte_r   [LIVE];

  logic [31:0]   ticks_r, ticks_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [IW-1:0] pend_slot_r, pend_slot_nxt;
  logic [1:0]    pend_q_r, pend_q_nxt;
  logic [7:0]    pend_b_r, pend_b_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          ok_r;
  logic [4:0]    slot_r;
  logic          fired_r;
  logic [1:0]    fq_r;
  logic [7:0]    fb_r;
  logic [31:0]   total_r;
  logic          last_r;

  mtb_pkg::func_t    func;
  mtb_pkg::slot_st_t cur_st;
  logic [31:0]       cur_rem;
  logic [31:0]       rem_dec;
  logic              sid_ok;
  logic [IW-1:0]     sid_ix;
  logic              running;
  logic              expire;
  logic              out_free;
  logic              stall_cond;
  logic              step_ok;
  logic              scan_end;
  logic              alloc_hit;

  logic              load;
  logic              ld_ok;
  logic [4:0]        ld_slot;
  logic              ld_fired;
  logic [1:0]        ld_q;
  logic [7:0]        ld_b;
  logic              ld_last;

  assign func       = mtb_pkg::func_t'(in_func);
  assign sid_ok     = ({27'd0, in_slot_id} < 32'(LIVE));
  assign sid_ix     = in_slot_id[IW-1:0];
  assign cur_st     = status_r[idx_r];
  assign cur_rem    = remain_r[idx_r];
  assign rem_dec    = cur_rem - 32'd1;
  assign running    = (cur_st == mtb_pkg::ST_RUN);
  assign expire     = running && (cur_rem == 32'd1);
  assign out_free   = !out_valid_r || out_ready;
  // An expiry with one already held needs the output register to pass the held one on.
  assign stall_cond = expire && pend_v_r && !out_free;
  assign step_ok    = cmd.tick_step && !stall_cond;
  assign scan_end   = (idx_r == IW'(LIVE - 1));
  assign alloc_hit  = (cur_st == mtb_pkg::ST_FREE);

  assign sts.out_free   = out_free;
  assign sts.scan_end   = scan_end;
  assign sts.alloc_hit  = alloc_hit;
  assign sts.tick_stall = stall_cond;

  always_comb begin
    load     = 1'b0;
    ld_ok    = 1'b0;
    ld_slot  = 5'd0;
    ld_fired = 1'b0;
    ld_q     = 2'd0;
    ld_b     = 8'd0;
    ld_last  = 1'b1;
    if (cmd.take_in) begin
      case (func)
        mtb_pkg::FN_ALLOC, mtb_pkg::FN_TICK: begin
          load = 1'b0;
        end
        mtb_pkg::FN_FREE, mtb_pkg::FN_BIND, mtb_pkg::FN_SETTIME: begin
          load  = 1'b1;
          ld_ok = sid_ok;
        end
        default: begin
          load = 1'b1;
        end
      endcase
    end
    if (cmd.alloc_step && (alloc_hit || scan_end)) begin
      load    = 1'b1;
      ld_ok   = alloc_hit;
      ld_slot = alloc_hit ? 5'(idx_r) : 5'd0;
    end
    if (step_ok && expire && pend_v_r) begin
      load     = 1'b1;
      ld_ok    = 1'b1;
      ld_slot  = 5'(pend_slot_r);
      ld_fired = 1'b1;
      ld_q     = pend_q_r;
      ld_b     = pend_b_r;
      ld_last  = 1'b0;
    end
    if (cmd.flush) begin
      load  = 1'b1;
      ld_ok = 1'b1;
      if (pend_v_r) begin
        ld_slot  = 5'(pend_slot_r);
        ld_fired = 1'b1;
        ld_q     = pend_q_r;
        ld_b     = pend_b_r;
      end
    end
  end

  always_comb begin
    ticks_nxt     = ticks_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_q_nxt    = pend_q_r;
    pend_b_nxt    = pend_b_r;
    if (cmd.take_in) begin
      idx_nxt    = '0;
      pend_v_nxt = 1'b0;
      if (func == mtb_pkg::FN_TICK) begin
        ticks_nxt = ticks_r + 32'd1;
      end
    end
    if ((cmd.alloc_step || step_ok) && !scan_end) begin
      idx_nxt = idx_r + IW'(1);
    end
    if (step_ok && expire) begin
      pend_v_nxt    = 1'b1;
      pend_slot_nxt = idx_r;
      pend_q_nxt    = queue_r[idx_r];
      pend_b_nxt    = byte_r[idx_r];
    end
    out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r     <= '0;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LIVE; i++) begin
        status_r[i] <= mtb_pkg::ST_FREE;
      end
    end else begin
      ticks_r     <= ticks_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.take_in && sid_ok) begin
        if (func == mtb_pkg::FN_FREE) begin
          status_r[sid_ix] <= mtb_pkg::ST_FREE;
        end else if (func == mtb_pkg::FN_SETTIME) begin
          status_r[sid_ix] <= mtb_pkg::ST_RUN;
        end
      end
      if (cmd.alloc_step && alloc_hit) begin
        status_r[idx_r] <= mtb_pkg::ST_ALLOC;
      end
      if (step_ok && expire) begin
        status_r[idx_r] <= mtb_pkg::ST_ALLOC;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    pend_q_r    <= pend_q_nxt;
    pend_b_r    <= pend_b_nxt;
    if (cmd.take_in && sid_ok && (func == mtb_pkg::FN_BIND)) begin
      queue_r[sid_ix] <= in_queue_id;
      byte_r[sid_ix]  <= in_event_byte;
    end
    if (cmd.take_in && sid_ok && (func == mtb_pkg::FN_SETTIME)) begin
      remain_r[sid_ix] <= in_timeout_ticks;
    end else if (step_ok && running) begin
      remain_r[idx_r] <= rem_dec;
    end
    if (load) begin
      ok_r    <= ld_ok;
      slot_r  <= ld_slot;
      fired_r <= ld_fired;
      fq_r    <= ld_q;
      fb_r    <= ld_b;
      total_r <= ticks_r;
      last_r  <= ld_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = ok_r;
  assign out_granted_slot = slot_r;
  assign out_fired        = fired_r;
  assign out_fire_queue   = fq_r;
  assign out_fire_byte    = fb_r;
  assign out_tick_total   = total_r;
  assign out_last         = last_r;

endmodule
`default_nettype wire

FILE: sv/multi_timer_bank.sv
// Free, bind, set timeout and unknown operations load their result into the output register on accept;
// alloc scans the slots from slot 0 until it finds a free slot or reaches the last one, L = min(NUM_SLOTS,32).
// Tick visits one slot per cycle while no expiry is stalled, and gives its final result from the flush state;
// each expiry after the first waits on the output register, so out_tready stalls lengthen it.
// One operation is in flight at a time; the next is taken once the output register can accept.
// Synchronous reset frees every slot and clears the tick count; there is no clearing pass.
`default_nettype none
module multi_timer_bank #(
  parameter int NUM_SLOTS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // slot_id[4:0], queue_id[6:5], event_byte[14:7], timeout_ticks[46:15], zero fill
  input  wire logic [mtb_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[2:0]
  input  wire logic [mtb_pkg::FUNC_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // ok[0], granted_slot[5:1], fire_queue[7:6], fire_byte[15:8], tick_total[47:16]
  output logic [mtb_pkg::OUT_DATA_W-1:0]      out_tdata,
  // fired[0]
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast
);

  mtb_pkg::dp_cmd_t cmd;
  mtb_pkg::dp_sts_t sts;

  logic        ok;
  logic [4:0]  granted_slot;
  logic        fired;
  logic [1:0]  fire_queue;
  logic [7:0]  fire_byte;
  logic [31:0] tick_total;

  mtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  mtb_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_tuser),
    .in_slot_id       (in_tdata[4:0]),
    .in_queue_id      (in_tdata[6:5]),
    .in_event_byte    (in_tdata[14:7]),
    .in_timeout_ticks (in_tdata[46:15]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_ok           (ok),
    .out_granted_slot (granted_slot),
    .out_fired        (fired),
    .out_fire_queue   (fire_queue),
    .out_fire_byte    (fire_byte),
    .out_tick_total   (tick_total),
    .out_last         (out_tlast)
  );

  assign out_tdata = {tick_total, fire_byte, fire_queue, granted_slot, ok};
  assign out_tuser = fired;

endmodule
`default_nettype wire

FILE: sv/mtb_checker.sv
// Port-level checker for the timer bank and its bind to the top level.
`default_nettype none
`include "multi_timer_bank_macros.svh"
module mtb_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [mtb_pkg::FUNC_W-1:0]     in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [mtb_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [0:0]                     out_tuser,
  input wire logic                           out_tlast
);

  logic scan_start;

  assign scan_start = in_tvalid && in_tready &&
                      ((in_tuser == mtb_pkg::FN_ALLOC) || (in_tuser == mtb_pkg::FN_TICK));

  // A result that is held back keeps its contents.
  `MTB_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled result changed")

  // A new operation is only taken when the output register has room for its result.
  `MTB_ASSERT_IMP(a_in_room, in_tready, !out_tvalid || out_tready, "input taken while output full")

  // Alloc and tick scan the slots, so the input closes for at least the next cycle.
  `MTB_ASSERT_NXT(a_scan_busy, scan_start, !in_tready, "input open during a slot scan")

  // An expiry report always says the operation succeeded.
  `MTB_ASSERT_IMP(a_fired_ok, out_tvalid && out_tuser[0], out_tdata[0], "expiry without ok")

endmodule

bind multi_timer_bank mtb_checker u_mtb_checker (.*);
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the timer slot bank: directed and random operations checked against a predictor.
module testbench;

  localparam int BANK_SLOTS = 32;
  localparam int TOTAL_OPS = 370;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS = 40;
  localparam logic [2:0] FN_UNUSED_LO = 3'd5;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;

  typedef struct packed {
    bit          hold;
    logic [2:0]  func;
    logic [4:0]  slot;
    logic [1:0]  queue;
    logic [7:0]  data;
    logic [31:0] timeout;
  } timer_op_t;

  typedef struct packed {
    bit        ok;
    bit [4:0]  slot;
    bit        fired;
    bit [1:0]  queue;
    bit [7:0]  data;
    bit [31:0] ticks;
    bit        last;
  } timer_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [mtb_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [mtb_pkg::FUNC_W-1:0]     in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [mtb_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [0:0]                     out_tuser;
  logic                           out_tlast;

  // Predicted contents of the bank.
  mtb_pkg::slot_st_t slot_state [BANK_SLOTS];
  logic [31:0]       slot_left [BANK_SLOTS];
  logic [1:0]        slot_queue [BANK_SLOTS];
  logic [7:0]        slot_data [BANK_SLOTS];
  logic [31:0]       tick_count;

  // Slots that have seen a bind; only these may be armed to expire.
  bit bound [BANK_SLOTS];
  bit hold_next;

  timer_op_t     pending_ops [$];
  timer_result_t expected_results [$];
  timer_op_t     cur_op;

  int ops_accepted = 0;
  int results_predicted = 0;
  int results_checked = 0;
  int error_count = 0;
  int fire_count = 0;
  int widest_tick = 0;
  int refused_allocs = 0;
  int cycle_count;
  int in_gap = 0;
  int in_quiet = 0;
  int out_stall = 0;
  int out_quiet = 0;

  multi_timer_bank #(.NUM_SLOTS(BANK_SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int next_gap(inout int quiet);
    int roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      quiet = $urandom_range(15, 40);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic add_op(input logic [2:0] func, input logic [4:0] slot, input logic [1:0] queue,
                        input logic [7:0] data, input logic [31:0] timeout);
    timer_op_t op;
    op.hold = hold_next;
    op.func = func;
    op.slot = slot;
    op.queue = queue;
    op.data = data;
    op.timeout = timeout;
    hold_next = 1'b0;
    // A slot that was never bound must not expire, so its count is kept out of reach.
    if (func == mtb_pkg::FN_SETTIME && !bound[slot]) op.timeout[31] = 1'b1;
    if (func == mtb_pkg::FN_BIND) bound[slot] = 1'b1;
    pending_ops.push_back(op);
  endtask

  task automatic add_rand(input logic [2:0] func);
    add_op(func, 5'($urandom), 2'($urandom), 8'($urandom), $urandom);
  endtask

  // Every 5-bit slot id names a real slot with a 32-slot bank, so no id is out of range.
  task automatic predict_op(input timer_op_t op);
    timer_result_t r;
    int fired_slots [$];
    bit found;
    r = '0;
    r.last = 1'b1;
    found = 1'b0;
    case (op.func)
      mtb_pkg::FN_ALLOC: begin
        for (int i = 0; i < BANK_SLOTS; i++) begin
          if (!found && slot_state[i] == mtb_pkg::ST_FREE) begin
            slot_state[i] = mtb_pkg::ST_ALLOC;
            r.slot = 5'(i);
            found = 1'b1;
          end
        end
        r.ok = found;
        if (!found) refused_allocs++;
      end
      mtb_pkg::FN_FREE: begin
        slot_state[op.slot] = mtb_pkg::ST_FREE;
        r.ok = 1'b1;
      end
      mtb_pkg::FN_BIND: begin
        slot_queue[op.slot] = op.queue;
        slot_data[op.slot] = op.data;
        r.ok = 1'b1;
      end
      mtb_pkg::FN_SETTIME: begin
        slot_left[op.slot] = op.timeout;
        slot_state[op.slot] = mtb_pkg::ST_RUN;
        r.ok = 1'b1;
      end
      mtb_pkg::FN_TICK: begin
        tick_count++;
        for (int i = 0; i < BANK_SLOTS; i++) begin
          if (slot_state[i] == mtb_pkg::ST_RUN) begin
            slot_left[i] = slot_left[i] - 32'd1;
            if (slot_left[i] == 32'd0) begin
              slot_state[i] = mtb_pkg::ST_ALLOC;
              fired_slots.push_back(i);
            end
          end
        end
        r.ok = 1'b1;
        r.ticks = tick_count;
        if (fired_slots.size() == 0) begin
          expected_results.push_back(r);
          results_predicted++;
        end
        for (int k = 0; k < fired_slots.size(); k++) begin
          r.slot = 5'(fired_slots[k]);
          r.fired = 1'b1;
          r.queue = slot_queue[fired_slots[k]];
          r.data = slot_data[fired_slots[k]];
          r.last = (k == fired_slots.size() - 1);
          expected_results.push_back(r);
          results_predicted++;
        end
        fire_count += fired_slots.size();
        if (fired_slots.size() > widest_tick) widest_tick = fired_slots.size();
      end
      default: begin
        r.ok = 1'b0;
      end
    endcase
    if (op.func != mtb_pkg::FN_TICK) begin
      r.ticks = tick_count;
      expected_results.push_back(r);
      results_predicted++;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] seen);
    if (want !== seen) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  // Driver: presents one operation at a time and predicts it when the transaction completes.
  always @(posedge clk) begin
    int owed;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_op(cur_op);
        ops_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        owed = results_predicted - results_checked - ((out_tvalid && out_tready) ? 1 : 0);
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0 && !(pending_ops[0].hold && owed != 0)) begin
          cur_op = pending_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, cur_op.timeout, cur_op.data, cur_op.queue, cur_op.slot};
          in_tuser <= cur_op.func;
          in_gap = next_gap(in_quiet);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    timer_result_t seen;
    timer_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.ok = out_tdata[0];
        seen.slot = out_tdata[5:1];
        seen.queue = out_tdata[7:6];
        seen.data = out_tdata[15:8];
        seen.ticks = out_tdata[47:16];
        seen.fired = out_tuser[0];
        seen.last = out_tlast;
        results_checked <= results_checked + 1;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("[%0t] unexpected result: expected none, actual %h", $time, seen);
        end else begin
          want = expected_results.pop_front();
          compare_field("ok", 32'(want.ok), 32'(seen.ok));
          compare_field("granted_slot", 32'(want.slot), 32'(seen.slot));
          compare_field("fired", 32'(want.fired), 32'(seen.fired));
          compare_field("fire_queue", 32'(want.queue), 32'(seen.queue));
          compare_field("fire_byte", 32'(want.data), 32'(seen.data));
          compare_field("tick_total", want.ticks, seen.ticks);
          compare_field("last", 32'(want.last), 32'(seen.last));
        end
        out_stall = next_gap(out_quiet);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] watchdog expired after %0d cycles", $time, LIMIT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int kind;
    int count;
    int common;
    int longest;
    int span;
    int sid;
    int total_ops;
    for (int i = 0; i < BANK_SLOTS; i++) begin
      slot_state[i] = mtb_pkg::ST_FREE;
      slot_left[i] = '0;
      slot_queue[i] = '0;
      slot_data[i] = '0;
      bound[i] = 1'b0;
    end
    tick_count = '0;
    hold_next = 1'b0;

    // Directed part.
    add_op(mtb_pkg::FN_TICK, 5'd0, 2'd0, 8'd0, 32'd0);
    add_op(mtb_pkg::FN_ALLOC, 5'd31, 2'd3, 8'hFF, 32'hFFFF_FFFF);
    add_op(mtb_pkg::FN_ALLOC, 5'd0, 2'd0, 8'd0, 32'd0);
    add_op(mtb_pkg::FN_BIND, 5'd0, 2'd3, 8'hFF, 32'd0);
    add_op(mtb_pkg::FN_BIND, 5'd1, 2'd0, 8'h00, 32'd0);
    add_op(mtb_pkg::FN_SETTIME, 5'd0, 2'd0, 8'd0, 32'd1);
    add_op(mtb_pkg::FN_SETTIME, 5'd1, 2'd0, 8'd0, 32'd2);
    add_op(mtb_pkg::FN_TICK, 5'd0, 2'd0, 8'd0, 32'd0);
    add_op(mtb_pkg::FN_TICK, 5'd0, 2'd0, 8'd0, 32'd0);
    // A zero count wraps on the first tick and never expires within the run.
    add_op(mtb_pkg::FN_SETTIME, 5'd1, 2'd0, 8'd0, 32'd0);
    add_op(mtb_pkg::FN_TICK, 5'd0, 2'd0, 8'd0, 32'd0);
    add_op(mtb_pkg::FN_SETTIME, 5'd0, 2'd0, 8'd0, 32'hFFFF_FFFF);
    add_op(mtb_pkg::FN_FREE, 5'd1, 2'd0, 8'd0, 32'd0);
    add_op(mtb_pkg::FN_FREE, 5'd31, 2'd0, 8'd0, 32'd0);
    // Bind and arm a free slot; it comes back as allocated after expiry.
    add_op(mtb_pkg::FN_BIND, 5'd31, 2'd2, 8'hA5, 32'd0);
    add_op(mtb_pkg::FN_SETTIME, 5'd31, 2'd0, 8'd0, 32'd1);
    add_op(mtb_pkg::FN_BIND, 5'd30, 2'd1, 8'h5A, 32'd0);
    add_op(mtb_pkg::FN_SETTIME, 5'd30, 2'd0, 8'd0, 32'd1);
    add_op(mtb_pkg::FN_TICK, 5'd0, 2'd0, 8'd0, 32'd0);
    add_op(mtb_pkg::FN_ALLOC, 5'd0, 2'd0, 8'd0, 32'd0);
    for (int f = FN_UNUSED_LO; f <= FN_UNUSED_HI; f++)
      add_rand(3'(f));

    // Fill the bank until an alloc is refused, then let the bench drain before going on.
    repeat (BANK_SLOTS + 1) add_rand(mtb_pkg::FN_ALLOC);
    hold_next = 1'b1;

    while (pending_ops.size() < TOTAL_OPS) begin
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
        // Whole timer life on a few slots, often with a shared count so several fire together.
        count = $urandom_range(1, 6);
        common = $urandom_range(1, 5);
        longest = 0;
        for (int k = 0; k < count; k++) begin
          sid = $urandom_range(0, BANK_SLOTS - 1);
          if ($urandom_range(0, 1) == 1)
            add_rand(mtb_pkg::FN_ALLOC);
          add_op(mtb_pkg::FN_BIND, 5'(sid), 2'($urandom), 8'($urandom), $urandom);
          span = ($urandom_range(0, 2) != 0) ? common : $urandom_range(1, 8);
          if (span > longest) longest = span;
          add_op(mtb_pkg::FN_SETTIME, 5'(sid), 2'($urandom), 8'($urandom), 32'(span));
        end
        repeat (longest + $urandom_range(0, 2))
          add_rand(mtb_pkg::FN_TICK);
        if ($urandom_range(0, 1) == 1)
          add_op(mtb_pkg::FN_FREE, 5'(sid), 2'($urandom), 8'($urandom), $urandom);
      end else if (kind < 15) begin
        repeat ($urandom_range(4, 10))
          add_rand(3'($urandom_range(0, FN_UNUSED_HI)));
      end else if (kind < 18) begin
        sid = $urandom_range(0, BANK_SLOTS - 1);
        span = $urandom_range(1, 3);
        add_op(mtb_pkg::FN_FREE, 5'(sid), 2'($urandom), 8'($urandom), $urandom);
        add_op(mtb_pkg::FN_SETTIME, 5'(sid), 2'($urandom), 8'($urandom), 32'(span));
        repeat (span) add_rand(mtb_pkg::FN_TICK);
      end else begin
        hold_next = 1'b1;
        repeat ($urandom_range(2, 6)) add_rand(mtb_pkg::FN_TICK);
      end
    end
    total_ops = pending_ops.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_accepted != total_ops) @(posedge clk);
    while (results_checked != results_predicted) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      error_count += expected_results.size();
      $display("[%0t] %0d results expected but never seen; first expected %h", $time,
               expected_results.size(), expected_results[0]);
    end

    $display("Ran %0d operations through %0d ticks; %0d results checked.",
             ops_accepted, tick_count, results_checked);
    $display("Saw %0d expiries (at most %0d on one tick) and %0d allocs refused on a full bank.",
             fire_count, widest_tick, refused_allocs);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
